/* rtl/core/indexed_ordered_list_unit_assert.svh */
// Assertion macros for the indexed ordered list unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IOL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IOL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/iol_pkg.sv */
// Shared types for the indexed ordered list unit.
// No dependencies.
`default_nettype none

package iol_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_POP    = 3'd4
    } iol_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } iol_status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  position;
        logic [31:0] value;
    } iol_req_t;

    typedef struct packed {
        iol_status_t status;
        logic [31:0] read_value;
        logic [6:0]  count;
    } iol_rsp_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } iol_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/indexed_ordered_list_unit.sv */
// Indexed ordered list unit: top level with command decode, count and result register.
// Depends on iol_pkg, iol_cell and indexed_ordered_list_unit_assert.svh.
//
// Holds up to CAPACITY unsigned entries in a row of cells, one entry per cell.
// Insert, append, remove, read and pop act on all cells together: every cell shifts,
// loads or holds on the same clock edge, so an item is accepted in every cycle
// while the result register is free or being drained. The result of an item is
// registered and appears in the cycle after it is accepted. Errors leave the list unchanged.
// No clearing pass follows reset; the list is empty at once.
`default_nettype none

`include "indexed_ordered_list_unit_assert.svh"

module indexed_ordered_list_unit
    import iol_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire iol_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output iol_rsp_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CNT_W > 7) ? CNT_W : 7;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    iol_rsp_t         rsp_reg;
    iol_rsp_t         rsp_next;

    logic              accept;
    logic [IDX_W-1:0]  pos_x;
    logic [IDX_W-1:0]  cnt_x;
    logic [IDX_W-1:0]  target;
    logic              full;
    logic              do_ins;
    logic              do_rem;
    logic              do_read;
    iol_status_t       status;
    iol_cmd_t          cmd;

    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_read  [CAPACITY];
    logic [VALUE_WIDTH-1:0] read_any;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign pos_x     = IDX_W'(req.position);
    assign cnt_x     = IDX_W'(cnt_reg);
    assign full      = (cnt_reg == CNT_W'(CAPACITY));
    assign new_value = VALUE_WIDTH'(req.value);

    // Decode the command against the current count.
    always_comb
    begin
        status  = ST_RANGE;
        target  = pos_x;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_read = 1'b0;
        unique case (iol_op_t'(req.opcode))
            OP_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status = ST_OK;
                    do_ins = 1'b1;
                end
            end
            OP_APPEND:
            begin
                target = cnt_x;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status = ST_OK;
                    do_ins = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_x < cnt_x)
                begin
                    status = ST_OK;
                    do_rem = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    status  = ST_OK;
                    do_read = 1'b1;
                end
            end
            OP_POP:
            begin
                target = cnt_x - IDX_W'(1);
                if (cnt_reg != '0)
                begin
                    status  = ST_OK;
                    do_rem  = 1'b1;
                    do_read = 1'b1;
                end
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    assign cmd.ins = accept & do_ins;
    assign cmd.rem = accept & do_rem;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_value;
            logic [VALUE_WIDTH-1:0] right_value;

            if (gi == 0)
            begin : g_first
                assign left_value = '0;
            end
            else
            begin : g_left
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_right
                assign right_value = cell_value[gi+1];
            end

            iol_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .IDX_W       (IDX_W),
                .IDX         (gi)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .target      (target),
                .new_value   (new_value),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .read_part   (cell_read[gi])
            );
        end
    endgenerate

    // Merge the one selected cell onto the read bus.
    always_comb
    begin
        read_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_any = read_any | cell_read[i];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.ins)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next      = accept | (rsp_valid_reg & rsp_stall);
        rsp_next            = rsp_reg;
        if (accept)
        begin
            rsp_next.status     = status;
            rsp_next.read_value = do_read ? 32'(read_any) : '0;
            rsp_next.count      = 7'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `IOL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `IOL_ASSERT_NOW(a_rsp_count, rsp_valid, rsp.count == 7'(cnt_reg), "result count stale")
    `IOL_ASSERT_NEXT(a_ins_grow, cmd.ins, cnt_reg == $past(cnt_reg) + CNT_W'(1), "insert lost")
    `IOL_ASSERT_NOW(a_ins_rem, 1'b1, !(cmd.ins && cmd.rem), "insert and remove together")

endmodule

`default_nettype wire

/* rtl/core/iol_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on iol_pkg.
`default_nettype none

module iol_cell
    import iol_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 7,
    parameter int IDX         = 0
) (
    input  wire logic                   clk,
    input  wire iol_cmd_t               cmd,
    input  wire logic [IDX_W-1:0]       target,
    input  wire logic [VALUE_WIDTH-1:0] new_value,
    input  wire logic [VALUE_WIDTH-1:0] left_value,
    input  wire logic [VALUE_WIDTH-1:0] right_value,
    output logic      [VALUE_WIDTH-1:0] value,
    output logic      [VALUE_WIDTH-1:0] read_part
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > target)
            begin
                value_next = left_value;
            end
            else if (MY_IDX == target)
            begin
                value_next = new_value;
            end
        end
        else if (cmd.rem)
        begin
            if (MY_IDX >= target)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign read_part = (MY_IDX == target) ? value_reg : '0;

endmodule

`default_nettype wire
